// ===== rtl/qes_pkg.sv =====
// shared types and defaults of the quadratic equation solver
package qes_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [2:0] {
        CLS_ANY     = 3'd0,
        CLS_NONE    = 3'd1,
        CLS_LINEAR  = 3'd2,
        CLS_TWO     = 3'd3,
        CLS_DOUBLE  = 3'd4,
        CLS_COMPLEX = 3'd5
    } t_sol_class;

endpackage

// ===== rtl/quadratic_equation_solver_top.sv =====
// quadratic equation solver top level: classify, discriminant, root, divide
//
//   channel   signals                                   direction
//   request   i_start, o_busy, i_coef_a/b/c             in
//   result    o_valid, o_solution_class, o_first_value,
//             o_second_value, o_overflow                out
//
// one request per cycle; o_busy stays low
// the pipeline depth is set by the root and divider chains
// (one root bit per stage over WORD_BITS+1 stages, one quotient bit per stage)
// synchronous active-low reset empties the pipeline
// results are shown for one cycle on o_valid; the receiver cannot stall
module quadratic_equation_solver_top #(
    parameter int WORD_BITS = qes_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = qes_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic signed [WORD_BITS-1:0] i_coef_a,
    input  logic signed [WORD_BITS-1:0] i_coef_b,
    input  logic signed [WORD_BITS-1:0] i_coef_c,
    output logic                        o_valid,
    output logic [2:0]                  o_solution_class,
    output logic signed [WORD_BITS-1:0] o_first_value,
    output logic signed [WORD_BITS-1:0] o_second_value,
    output logic                        o_overflow
);
    import qes_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int DW   = 2 * W + 2;
    localparam int RTW  = DW / 2;
    localparam int NUMW = W + 3;
    localparam int DENW = W + 1;
    localparam int LAT  = 7 + RTW + NUMW + FRAC_BITS + 1;

    typedef struct packed {
        logic                az;
        logic                bz;
        logic                cz;
        logic                an;
        logic                bn;
        logic                cn;
        logic signed [W-1:0] b;
        logic signed [W-1:0] c;
        logic [W-1:0]        am;
        logic [W-1:0]        bm;
    } t_pre;

    typedef struct packed {
        logic                az;
        logic                bz;
        logic                cz;
        logic                an;
        logic                bn;
        logic                dneg;
        logic                dzero;
        logic signed [W-1:0] b;
        logic signed [W-1:0] c;
        logic [W-1:0]        am;
        logic [W-1:0]        bm;
    } t_sq_side;

    // input register
    logic                r_v0;
    logic signed [W-1:0] r_a;
    logic signed [W-1:0] r_b;
    logic signed [W-1:0] r_c;
    t_pre                pre;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_start && !o_busy;
        end
        r_a <= i_coef_a;
        r_b <= i_coef_b;
        r_c <= i_coef_c;
    end

    always_comb begin
        pre.an = r_a[W-1];
        pre.bn = r_b[W-1];
        pre.cn = r_c[W-1];
        pre.am = pre.an ? W'(-r_a) : W'(r_a);
        pre.bm = pre.bn ? W'(-r_b) : W'(r_b);
        pre.az = r_a == '0;
        pre.bz = r_b == '0;
        pre.cz = r_c == '0;
        pre.b  = r_b;
        pre.c  = r_c;
    end

    logic [W-1:0] cm;
    assign cm = pre.cn ? W'(-r_c) : W'(r_c);

    // products
    logic          mul_v;
    logic [2*W-1:0] prod_bb;
    logic [2*W-1:0] prod_ac;
    t_pre          r_pre1;
    t_pre          r_pre2;

    qes_mul #(.X_BITS(W)) u_mul_bb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_x     (pre.bm),
        .i_y     (pre.bm),
        .o_valid (mul_v),
        .o_prod  (prod_bb)
    );

    qes_mul #(.X_BITS(W)) u_mul_ac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_x     (pre.am),
        .i_y     (cm),
        .o_valid (),
        .o_prod  (prod_ac)
    );

    always_ff @(posedge i_clk) begin
        r_pre1 <= pre;
        r_pre2 <= r_pre1;
    end

    // discriminant
    logic [DW-1:0] b2;
    logic [DW-1:0] t4;
    logic [DW-1:0] n_dmag;
    logic          n_dneg;
    logic          r_vd;
    logic [DW-1:0] r_dmag;
    t_sq_side      r_dside;

    assign b2 = {2'b00, prod_bb};
    assign t4 = {prod_ac, 2'b00};

    always_comb begin
        n_dneg = 1'b0;
        if (r_pre2.an != r_pre2.cn) begin
            n_dmag = b2 + t4;
        end else if (b2 >= t4) begin
            n_dmag = b2 - t4;
        end else begin
            n_dmag = t4 - b2;
            n_dneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else begin
            r_vd <= mul_v;
        end
        r_dmag        <= n_dmag;
        r_dside.az    <= r_pre2.az;
        r_dside.bz    <= r_pre2.bz;
        r_dside.cz    <= r_pre2.cz;
        r_dside.an    <= r_pre2.an;
        r_dside.bn    <= r_pre2.bn;
        r_dside.dneg  <= n_dneg;
        r_dside.dzero <= n_dmag == '0;
        r_dside.b     <= r_pre2.b;
        r_dside.c     <= r_pre2.c;
        r_dside.am    <= r_pre2.am;
        r_dside.bm    <= r_pre2.bm;
    end

    // square root
    logic           sq_v;
    logic [RTW-1:0] sq_root;
    t_sq_side       sq_side;

    qes_sqrt #(.OP_BITS(DW), .SIDE_BITS($bits(t_sq_side))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vd),
        .i_op    (r_dmag),
        .i_side  (r_dside),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // numerators and denominator
    logic signed [NUMW-1:0] b_ext;
    logic signed [NUMW-1:0] s_ext;
    logic signed [NUMW-1:0] nb;
    logic signed [NUMW-1:0] nc;
    t_sol_class             n_cls;
    logic signed [NUMW-1:0] n_num1;
    logic signed [NUMW-1:0] n_num2;
    logic [DENW-1:0]        n_den;
    logic                   n_dn;
    logic                   n_use1;
    logic                   n_use2;

    logic                   r_vn;
    t_sol_class             r_cls;
    logic signed [NUMW-1:0] r_num1;
    logic signed [NUMW-1:0] r_num2;
    logic [DENW-1:0]        r_den;
    logic                   r_dn;
    logic                   r_use1;
    logic                   r_use2;

    assign b_ext = NUMW'(sq_side.b);
    assign s_ext = {2'b00, sq_root};
    assign nb    = -b_ext;
    assign nc    = -NUMW'(sq_side.c);

    always_comb begin
        n_cls  = CLS_ANY;
        n_num1 = nb;
        n_num2 = s_ext;
        n_den  = {sq_side.am, 1'b0};
        n_dn   = sq_side.an;
        n_use1 = 1'b1;
        n_use2 = 1'b1;
        if (sq_side.az && sq_side.bz) begin
            n_cls  = sq_side.cz ? CLS_ANY : CLS_NONE;
            n_use1 = 1'b0;
            n_use2 = 1'b0;
        end else if (sq_side.az) begin
            n_cls  = CLS_LINEAR;
            n_num1 = nc;
            n_den  = {1'b0, sq_side.bm};
            n_dn   = sq_side.bn;
            n_use2 = 1'b0;
        end else if (sq_side.dzero) begin
            n_cls  = CLS_DOUBLE;
            n_use2 = 1'b0;
        end else if (!sq_side.dneg) begin
            n_cls  = CLS_TWO;
            n_num1 = nb + s_ext;
            n_num2 = nb - s_ext;
        end else begin
            n_cls  = CLS_COMPLEX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vn <= 1'b0;
        end else begin
            r_vn <= sq_v;
        end
        r_cls  <= n_cls;
        r_num1 <= n_num1;
        r_num2 <= n_num2;
        r_den  <= n_den;
        r_dn   <= n_dn;
        r_use1 <= n_use1;
        r_use2 <= n_use2;
    end

    // quotients
    logic                dv_v;
    logic signed [W-1:0] q1;
    logic signed [W-1:0] q2;
    logic                ov1;
    logic                ov2;
    logic [2:0]          dv_cls;

    qes_div #(
        .WORD_BITS (W),
        .FRAC_BITS (FRAC_BITS),
        .NUM_BITS  (NUMW),
        .DEN_BITS  (DENW),
        .SIDE_BITS (3)
    ) u_div_first (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_vn),
        .i_num     (r_num1),
        .i_den_neg (r_dn),
        .i_den     (r_den),
        .i_use     (r_use1),
        .i_side    (r_cls),
        .o_valid   (dv_v),
        .o_value   (q1),
        .o_ovf     (ov1),
        .o_side    (dv_cls)
    );

    qes_div #(
        .WORD_BITS (W),
        .FRAC_BITS (FRAC_BITS),
        .NUM_BITS  (NUMW),
        .DEN_BITS  (DENW),
        .SIDE_BITS (1)
    ) u_div_second (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_vn),
        .i_num     (r_num2),
        .i_den_neg (r_dn),
        .i_den     (r_den),
        .i_use     (r_use2),
        .i_side    (1'b0),
        .o_valid   (),
        .o_value   (q2),
        .o_ovf     (ov2),
        .o_side    ()
    );

    // result register
    logic                r_ov;
    logic [2:0]          r_ocls;
    logic signed [W-1:0] r_first;
    logic signed [W-1:0] r_second;
    logic                r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= dv_v;
        end
        r_ocls   <= dv_cls;
        r_first  <= q1;
        r_second <= q2;
        r_ovf    <= ov1 | ov2;
    end

    assign o_valid          = r_ov;
    assign o_solution_class = r_ocls;
    assign o_first_value    = r_first;
    assign o_second_value   = r_second;
    assign o_overflow       = r_ovf;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |-> ##LAT o_valid)
        else $error("request did not produce a result at the pipeline depth");

    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_solution_class == CLS_ANY || o_solution_class == CLS_NONE)
        |-> o_first_value == '0 && o_second_value == '0 && !o_overflow)
        else $error("degenerate class carries values");

    a_single_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_solution_class == CLS_LINEAR || o_solution_class == CLS_DOUBLE)
        |-> o_second_value == '0)
        else $error("single-root class has a second value");

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_solution_class <= CLS_COMPLEX)
        else $error("solution class code out of range");

endmodule

// ===== rtl/qes_mul.sv =====
// two-stage unsigned multiplier built from four partial products
module qes_mul #(
    parameter int X_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [X_BITS-1:0]     i_x,
    input  logic [X_BITS-1:0]     i_y,
    output logic                  o_valid,
    output logic [2*X_BITS-1:0]   o_prod
);
    localparam int LO = X_BITS / 2;
    localparam int HI = X_BITS - LO;
    localparam int PW = 2 * X_BITS;

    logic            r_v1;
    logic [2*LO-1:0] r_p00;
    logic [LO+HI-1:0] r_p01;
    logic [LO+HI-1:0] r_p10;
    logic [2*HI-1:0] r_p11;
    logic            r_v2;
    logic [PW-1:0]   r_prod;
    logic [PW-1:0]   n_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_p00  <= {{LO{1'b0}}, i_x[LO-1:0]} * {{LO{1'b0}}, i_y[LO-1:0]};
        r_p01  <= {{HI{1'b0}}, i_x[LO-1:0]} * {{LO{1'b0}}, i_y[X_BITS-1:LO]};
        r_p10  <= {{LO{1'b0}}, i_x[X_BITS-1:LO]} * {{HI{1'b0}}, i_y[LO-1:0]};
        r_p11  <= {{HI{1'b0}}, i_x[X_BITS-1:LO]} * {{HI{1'b0}}, i_y[X_BITS-1:LO]};
        r_prod <= n_prod;
    end

    always_comb begin
        n_prod = {{(PW-2*LO){1'b0}}, r_p00}
               + ({{(PW-LO-HI){1'b0}}, r_p01} << LO)
               + ({{(PW-LO-HI){1'b0}}, r_p10} << LO)
               + ({{(PW-2*HI){1'b0}}, r_p11} << (2*LO));
    end

    assign o_valid = r_v2;
    assign o_prod  = r_prod;

endmodule

// ===== rtl/qes_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module qes_sqrt #(
    parameter int OP_BITS   = 66,
    parameter int SIDE_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [OP_BITS-1:0]     i_op,
    input  logic [SIDE_BITS-1:0]   i_side,
    output logic                   o_valid,
    output logic [OP_BITS/2-1:0]   o_root,
    output logic [SIDE_BITS-1:0]   o_side
);
    localparam int N  = OP_BITS / 2;
    localparam int RW = N + 3;

    logic                 r_v    [0:N-1];
    logic [RW-1:0]        r_rem  [0:N-1];
    logic [N-1:0]         r_root [0:N-1];
    logic [OP_BITS-1:0]   r_op   [0:N-1];
    logic [SIDE_BITS-1:0] r_side [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                 s_v;
        logic [RW-1:0]        s_rem;
        logic [N-1:0]         s_root;
        logic [OP_BITS-1:0]   s_op;
        logic [SIDE_BITS-1:0] s_side;
        logic [RW-1:0]        t_rem;
        logic [RW-1:0]        trial;
        logic                 take;

        if (k == 0) begin : g_first
            assign s_v    = i_valid;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_op   = i_op;
            assign s_side = i_side;
        end else begin : g_next
            assign s_v    = r_v[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_op   = r_op[k-1];
            assign s_side = r_side[k-1];
        end

        assign t_rem = {s_rem[RW-3:0], s_op[OP_BITS-1-2*k -: 2]};
        assign trial = {1'b0, s_root, 2'b01};
        assign take  = t_rem >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= s_v;
            end
            r_rem[k]  <= take ? t_rem - trial : t_rem;
            r_root[k] <= {s_root[N-2:0], take};
            r_op[k]   <= s_op;
            r_side[k] <= s_side;
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

// ===== rtl/qes_div.sv =====
// pipelined restoring divider with round-half-away and saturation
module qes_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int NUM_BITS  = 35,
    parameter int DEN_BITS  = 33,
    parameter int SIDE_BITS = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [NUM_BITS-1:0]  i_num,
    input  logic                        i_den_neg,
    input  logic [DEN_BITS-1:0]         i_den,
    input  logic                        i_use,
    input  logic [SIDE_BITS-1:0]        i_side,
    output logic                        o_valid,
    output logic signed [WORD_BITS-1:0] o_value,
    output logic                        o_ovf,
    output logic [SIDE_BITS-1:0]        o_side
);
    localparam int NW = NUM_BITS + FRAC_BITS + 1;

    logic                 r_v    [0:NW-1];
    logic [DEN_BITS-1:0]  r_rem  [0:NW-1];
    logic [NW-1:0]        r_quo  [0:NW-1];
    logic [NW-1:0]        r_n    [0:NW-1];
    logic [DEN_BITS-1:0]  r_den  [0:NW-1];
    logic                 r_neg  [0:NW-1];
    logic                 r_use  [0:NW-1];
    logic [SIDE_BITS-1:0] r_side [0:NW-1];

    logic                 in_neg;
    logic [NUM_BITS-1:0]  in_mag;

    assign in_neg = i_num[NUM_BITS-1] ^ i_den_neg;
    assign in_mag = i_num[NUM_BITS-1] ? NUM_BITS'(-i_num) : NUM_BITS'(i_num);

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic                 s_v;
        logic [DEN_BITS-1:0]  s_rem;
        logic [NW-1:0]        s_quo;
        logic [NW-1:0]        s_n;
        logic [DEN_BITS-1:0]  s_den;
        logic                 s_neg;
        logic                 s_use;
        logic [SIDE_BITS-1:0] s_side;
        logic [DEN_BITS:0]    t_rem;
        logic [DEN_BITS:0]    diff;
        logic                 take;

        if (k == 0) begin : g_first
            assign s_v    = i_valid;
            assign s_rem  = '0;
            assign s_quo  = '0;
            assign s_n    = {in_mag, {(FRAC_BITS+1){1'b0}}};
            assign s_den  = i_den;
            assign s_neg  = in_neg;
            assign s_use  = i_use;
            assign s_side = i_side;
        end else begin : g_next
            assign s_v    = r_v[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_quo  = r_quo[k-1];
            assign s_n    = r_n[k-1];
            assign s_den  = r_den[k-1];
            assign s_neg  = r_neg[k-1];
            assign s_use  = r_use[k-1];
            assign s_side = r_side[k-1];
        end

        assign t_rem = {s_rem, s_n[NW-1-k]};
        assign diff  = t_rem - {1'b0, s_den};
        assign take  = t_rem >= {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= s_v;
            end
            r_rem[k]  <= take ? diff[DEN_BITS-1:0] : t_rem[DEN_BITS-1:0];
            r_quo[k]  <= {s_quo[NW-2:0], take};
            r_n[k]    <= s_n;
            r_den[k]  <= s_den;
            r_neg[k]  <= s_neg;
            r_use[k]  <= s_use;
            r_side[k] <= s_side;
        end
    end

    logic [NW:0]                 q_inc;
    logic [NW-1:0]               q_rnd;
    logic [NW-1:0]               limit;
    logic                        sat;
    logic [WORD_BITS-1:0]        mag;
    logic                        r_ov;
    logic signed [WORD_BITS-1:0] r_value;
    logic                        r_ovf;
    logic [SIDE_BITS-1:0]        r_oside;

    assign q_inc = {1'b0, r_quo[NW-1]} + (NW+1)'(1);
    assign q_rnd = q_inc[NW:1];
    assign limit = r_neg[NW-1] ? (NW'(1) << (WORD_BITS-1))
                               : ((NW'(1) << (WORD_BITS-1)) - NW'(1));
    assign sat   = q_rnd > limit;
    assign mag   = sat ? limit[WORD_BITS-1:0] : q_rnd[WORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[NW-1];
        end
        if (!r_use[NW-1]) begin
            r_value <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_value <= r_neg[NW-1] ? -mag : mag;
            r_ovf   <= sat;
        end
        r_oside <= r_side[NW-1];
    end

    assign o_valid = r_ov;
    assign o_value = r_value;
    assign o_ovf   = r_ovf;
    assign o_side  = r_oside;

endmodule
